### hw/rtl/uels_pkg.sv
`timescale 1ns / 1ps
package uels_pkg;
	localparam int MaxLines = 1024;
	localparam int AddrW = $clog2(MaxLines);
	localparam int CntW = AddrW + 1;
	localparam int SlopeW = 32;
	localparam int IcptW = 48;
	localparam int StartW = 50;
	localparam int ValW = 64;
	localparam int NumW = 49;
	localparam int DenW = 33;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_SLOPE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ARD, S_ATOP, S_DIVGO, S_DIVW, S_ACMP, S_AWR,
		S_QRD, S_QCMP, S_QLRD, S_QMUL, S_QADD, S_DONE
	} state_t;

	typedef struct packed {
		logic                     go;
		logic signed [NumW-1:0]   num;
		logic        [DenW-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [StartW-1:0] quot;
	} div_rsp_t;
endpackage

### hw/rtl/uels_ceil_div.sv
`timescale 1ns / 1ps
module uels_ceil_div (
	input  logic                clk,
	input  logic                arst_n,
	input  uels_pkg::div_req_t  req,
	output uels_pkg::div_rsp_t  rsp
);
	localparam int NW = uels_pkg::NumW;
	localparam int DW = uels_pkg::DenW;
	localparam int SW = uels_pkg::StartW;
	localparam int BW = $clog2(NW + 1);

	logic          busy_q;
	logic [BW-1:0] bit_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic [NW-1:0] mag;
	logic signed [SW-1:0] qs;

	assign mag   = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(NW);
				quo_q  <= mag;
				rem_q  <= '0;
				den_q  <= req.den;
				neg_q  <= req.num[NW-1];
			end else if (busy_q) begin
				if (!diff[DW]) begin
					rem_q <= diff;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
				if (bit_q == BW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (neg_q)
			qs = -SW'(quo_q);
		else
			qs = SW'(quo_q) + SW'(rem_q != '0);
		rsp.done = done_q;
		rsp.quot = qs;
	end
endmodule

### hw/rtl/uels_line_mem.sv
`timescale 1ns / 1ps
module uels_line_mem (
	input  logic                                clk,
	input  logic [uels_pkg::AddrW-1:0]          raddr,
	output logic signed [uels_pkg::SlopeW-1:0]  rslope,
	output logic signed [uels_pkg::IcptW-1:0]   ricpt,
	output logic signed [uels_pkg::StartW-1:0]  rstart,
	input  logic                                we,
	input  logic [uels_pkg::AddrW-1:0]          waddr,
	input  logic signed [uels_pkg::SlopeW-1:0]  wslope,
	input  logic signed [uels_pkg::IcptW-1:0]   wicpt,
	input  logic signed [uels_pkg::StartW-1:0]  wstart
);
	localparam int EW = uels_pkg::SlopeW + uels_pkg::IcptW + uels_pkg::StartW;
	logic [EW-1:0] mem [uels_pkg::MaxLines];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {wslope, wicpt, wstart};
		rd_q <= mem[raddr];
	end

	assign {rslope, ricpt, rstart} = rd_q;
endmodule

### hw/rtl/upper_envelope_line_store_unit.sv
`timescale 1ns / 1ps
// Upper envelope of lines kept in a 1024-entry line memory with registered reads. Each request
// gives exactly one result on the strobe; the receiver cannot stall it, so the result must be
// taken in the cycle it appears. A query runs up to ten binary-search steps, each a memory
// read and then a compare, then reads the chosen line and forms slope times x plus intercept.
// An add runs the bit-serial ceiling divider once per examined line.
module upper_envelope_line_store_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic signed [31:0]   slope,
	input  logic signed [47:0]   intercept,
	input  logic signed [31:0]   query_x,
	output logic                 strobe,
	output logic signed [63:0]   envelope_value,
	output logic [1:0]           status,
	output logic [10:0]          line_count
);
	localparam int AW = uels_pkg::AddrW;
	localparam int CW = uels_pkg::CntW;
	localparam int SW = uels_pkg::StartW;

	uels_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, keep_q, lo_q, hi_q;
	logic signed [31:0] k_q, x_q;
	logic signed [47:0] b_q;
	logic signed [SW-1:0] meet_q;
	logic signed [63:0] val_q, prod_q;
	uels_pkg::status_t st_q;
	logic strobe_q;
	logic first_q;

	logic [AW-1:0] raddr;
	logic signed [31:0] rslope;
	logic signed [47:0] ricpt;
	logic signed [SW-1:0] rstart;
	logic we;
	uels_pkg::div_req_t dreq;
	uels_pkg::div_rsp_t drsp;
	logic [CW-1:0] mid;
	logic slope_bad;
	logic pop_top;
	logic store_full;

	assign mid = lo_q + ((hi_q - lo_q + CW'(1)) >> 1);
	assign slope_bad  = (keep_q == count_q) && (k_q <= rslope);
	assign pop_top    = (keep_q > CW'(1)) && (drsp.quot <= rstart);
	assign store_full = (keep_q >= CW'(uels_pkg::MaxLines));

	uels_line_mem u_mem (
		.clk(clk), .raddr(raddr), .rslope(rslope), .ricpt(ricpt), .rstart(rstart),
		.we(we), .waddr(keep_q[AW-1:0]), .wslope(k_q), .wicpt(b_q), .wstart(meet_q)
	);

	uels_ceil_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		dreq.go  = (state_q == uels_pkg::S_DIVGO);
		dreq.num = uels_pkg::NumW'(ricpt) - uels_pkg::NumW'(b_q);
		dreq.den = uels_pkg::DenW'(k_q) - uels_pkg::DenW'(rslope);
	end

	always_comb begin
		raddr = '0;
		unique case (state_q)
			uels_pkg::S_ARD:  raddr = AW'(keep_q - CW'(1));
			uels_pkg::S_QRD:  raddr = mid[AW-1:0];
			uels_pkg::S_QLRD, uels_pkg::S_QMUL: raddr = lo_q[AW-1:0];
			default:          raddr = AW'(keep_q - CW'(1));
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uels_pkg::S_IDLE: begin
				if (start) begin
					unique case (uels_pkg::op_t'(operation))
						uels_pkg::OP_ADD:   state_d = (count_q == '0) ? uels_pkg::S_AWR
							: uels_pkg::S_ARD;
						uels_pkg::OP_QUERY: state_d = (count_q == '0) ? uels_pkg::S_DONE
							: uels_pkg::S_QCMP;
						default:            state_d = uels_pkg::S_DONE;
					endcase
				end
			end
			uels_pkg::S_ARD:  state_d = uels_pkg::S_ATOP;
			uels_pkg::S_ATOP: state_d = slope_bad ? uels_pkg::S_DONE : uels_pkg::S_DIVGO;
			uels_pkg::S_DIVGO: state_d = uels_pkg::S_DIVW;
			uels_pkg::S_DIVW: if (drsp.done) state_d = uels_pkg::S_ACMP;
			uels_pkg::S_ACMP: begin
				if (pop_top)
					state_d = uels_pkg::S_ARD;
				else if (store_full)
					state_d = uels_pkg::S_DONE;
				else
					state_d = uels_pkg::S_AWR;
			end
			uels_pkg::S_AWR:  state_d = uels_pkg::S_DONE;
			uels_pkg::S_QRD:  state_d = uels_pkg::S_QCMP;
			uels_pkg::S_QCMP: state_d = (lo_q < hi_q) ? uels_pkg::S_QRD : uels_pkg::S_QLRD;
			uels_pkg::S_QLRD: state_d = uels_pkg::S_QMUL;
			uels_pkg::S_QMUL: state_d = uels_pkg::S_QADD;
			uels_pkg::S_QADD: state_d = uels_pkg::S_DONE;
			uels_pkg::S_DONE: state_d = uels_pkg::S_IDLE;
			default:          state_d = uels_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= uels_pkg::S_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == uels_pkg::S_DONE);
			if (state_q == uels_pkg::S_IDLE && start
					&& uels_pkg::op_t'(operation) == uels_pkg::OP_CLEAR)
				count_q <= '0;
			if (state_q == uels_pkg::S_AWR)
				count_q <= keep_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		we <= 1'b0;
		unique case (state_q)
			uels_pkg::S_IDLE: begin
				k_q   <= slope;
				b_q   <= intercept;
				x_q   <= query_x;
				keep_q <= count_q;
				lo_q  <= '0;
				hi_q  <= count_q - CW'(1);
				val_q <= '0;
				meet_q <= '0;
				st_q  <= (uels_pkg::op_t'(operation) == uels_pkg::OP_QUERY && count_q == '0)
					? uels_pkg::ST_EMPTY : uels_pkg::ST_OK;
				if (start && uels_pkg::op_t'(operation) == uels_pkg::OP_ADD && count_q == '0)
					we <= 1'b1;
			end
			uels_pkg::S_ATOP: begin
				if (slope_bad)
					st_q <= uels_pkg::ST_SLOPE;
			end
			uels_pkg::S_ACMP: begin
				meet_q <= drsp.quot;
				if (pop_top)
					keep_q <= keep_q - CW'(1);
				else if (store_full)
					st_q <= uels_pkg::ST_FULL;
				else
					we <= 1'b1;
			end
			uels_pkg::S_QCMP: begin
				if (lo_q < hi_q && !first_q) begin
					if (rstart <= SW'(x_q))
						lo_q <= mid;
					else
						hi_q <= mid - CW'(1);
				end
			end
			uels_pkg::S_QMUL: prod_q <= 64'(rslope) * 64'(x_q);
			uels_pkg::S_QADD: val_q  <= prod_q + 64'(ricpt);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			first_q <= 1'b0;
		else
			first_q <= (state_q == uels_pkg::S_IDLE);
	end

	assign busy           = (state_q != uels_pkg::S_IDLE);
	assign strobe         = strobe_q;
	assign envelope_value = val_q;
	assign status         = st_q;
	assign line_count     = 11'(count_q);
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import uels_pkg::*;

	typedef struct {
		logic signed [63:0] value;
		status_t            st;
		logic [10:0]        cnt;
	} env_res_t;

	typedef struct {
		op_t                op;
		logic signed [31:0] k;
		logic signed [47:0] b;
		logic signed [31:0] x;
		bit                 typed;
		env_res_t           res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic signed [31:0] slope;
	logic signed [47:0] intercept;
	logic signed [31:0] query_x;
	logic               strobe;
	logic signed [63:0] envelope_value;
	logic [1:0]         status;
	logic [10:0]        line_count;

	longint   env_k[MaxLines];
	longint   env_b[MaxLines];
	longint   env_from[MaxLines];
	int       env_cnt;
	env_res_t pending_q[$];
	int       errors;
	int       idle_pct;
	longint   cycles;
	stim_row_t rows[$];

	upper_envelope_line_store_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .slope(slope), .intercept(intercept), .query_x(query_x),
		.strobe(strobe), .envelope_value(envelope_value), .status(status),
		.line_count(line_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint ceil_quot(longint num, longint den);
		longint q;
		q = num / den;
		if (num % den > 0)
			q++;
		return q;
	endfunction

	function automatic env_res_t envelope_apply(op_t op, longint k, longint b, longint x);
		env_res_t r;
		int keep;
		int lo;
		int hi;
		int mid;
		r.value = 0;
		r.st = ST_OK;
		case (op)
			OP_CLEAR: env_cnt = 0;
			OP_ADD: begin
				if (env_cnt > 0 && k <= env_k[env_cnt-1]) begin
					r.st = ST_SLOPE;
				end else begin
					keep = env_cnt;
					while (keep > 1 && ceil_quot(env_b[keep-1] - b, k - env_k[keep-1])
							<= env_from[keep-1])
						keep--;
					if (keep >= MaxLines) begin
						r.st = ST_FULL;
					end else begin
						env_from[keep] = (keep > 0) ?
							ceil_quot(env_b[keep-1] - b, k - env_k[keep-1]) : 0;
						env_k[keep] = k;
						env_b[keep] = b;
						env_cnt = keep + 1;
					end
				end
			end
			OP_QUERY: begin
				if (env_cnt == 0) begin
					r.st = ST_EMPTY;
				end else begin
					lo = 0;
					hi = env_cnt - 1;
					while (lo < hi) begin
						mid = lo + (hi - lo + 1) / 2;
						if (env_from[mid] <= x)
							lo = mid;
						else
							hi = mid - 1;
					end
					r.value = env_k[lo] * x + env_b[lo];
				end
			end
			default: ;
		endcase
		r.cnt = env_cnt[10:0];
		return r;
	endfunction

	task automatic issue(op_t op, longint k, longint b, longint x, bit typed,
			env_res_t typed_res);
		env_res_t r;
		int gap;
		logic signed [31:0] k_n;
		logic signed [47:0] b_n;
		logic signed [31:0] x_n;
		k_n = 32'(k);
		b_n = 48'(b);
		x_n = 32'(x);
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		slope <= k_n;
		intercept <= b_n;
		query_x <= x_n;
		do @(posedge clk); while (busy);
		r = envelope_apply(op, k_n, b_n, x_n);
		pending_q.push_back(typed ? typed_res : r);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (pending_q.size() == 0);
		@(posedge clk);
	endtask

	task automatic add_row(op_t op, longint k, longint b, longint x, bit typed = 0,
			longint v = 0, status_t st = ST_OK, int c = 0);
		stim_row_t s;
		s.op = op;
		s.k = 32'(k);
		s.b = 48'(b);
		s.x = 32'(x);
		s.typed = typed;
		s.res.value = v;
		s.res.st = st;
		s.res.cnt = 11'(c);
		rows.push_back(s);
	endtask

	always @(posedge clk) begin
		env_res_t e;
		if (arst_n && strobe) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result: value %0d status %0d count %0d",
					envelope_value, status, line_count);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (envelope_value !== e.value) begin
					$error("envelope_value: expected %0d, got %0d", e.value, envelope_value);
					errors++;
				end
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					errors++;
				end
				if (line_count !== e.cnt) begin
					$error("line_count: expected %0d, got %0d", e.cnt, line_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		env_res_t none;
		stim_row_t s;
		int p;
		int n;
		int pick;
		longint k;
		longint b;
		longint x;
		none.value = 0;
		none.st = ST_OK;
		none.cnt = 0;
		errors = 0;
		cycles = 0;
		env_cnt = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_CLEAR;
		slope = '0;
		intercept = '0;
		query_x = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(OP_QUERY, 0, 0, 5, 1, 0, ST_EMPTY, 0);
		add_row(OP_NONE, -1, -1, -1, 1, 0, ST_OK, 0);
		add_row(OP_ADD, -64'sd2147483648, 64'sd140737488355327, 0, 1, 0, ST_OK, 1);
		add_row(OP_QUERY, 0, 0, 64'sd2147483647);
		add_row(OP_ADD, -64'sd2147483648, 0, 0, 1, 0, ST_SLOPE, 1);
		add_row(OP_ADD, 0, -64'sd140737488355328, 0);
		add_row(OP_ADD, 64'sd2147483647, 0, 0);
		add_row(OP_QUERY, 0, 0, -64'sd2147483648);
		add_row(OP_QUERY, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, -1);
		add_row(OP_QUERY, 0, 0, 64'sd2147483647);
		add_row(OP_ADD, 64'sd2147483647, 5, 0);
		add_row(OP_CLEAR, 0, 0, 0, 1, 0, ST_OK, 0);
		add_row(OP_ADD, 1, 0, 0, 1, 0, ST_OK, 1);
		add_row(OP_ADD, 2, 0, 0, 1, 0, ST_OK, 2);
		add_row(OP_ADD, 3, 0, 0);
		add_row(OP_ADD, 5, 7, 0);
		add_row(OP_ADD, 6, -20, 0);
		add_row(OP_QUERY, 0, 0, -3);
		add_row(OP_QUERY, 0, 0, -4);
		add_row(OP_QUERY, 0, 0, 100);
		add_row(OP_NONE, 9, 9, 9);
		add_row(OP_CLEAR, 0, 0, 0, 1, 0, ST_OK, 0);
		foreach (rows[i]) begin
			s = rows[i];
			issue(s.op, s.k, s.b, s.x, s.typed, s.res);
		end
		drain();

		// Fill the store with lines that all stay on the envelope, then overflow it.
		for (int i = 0; i <= MaxLines; i++)
			issue(OP_ADD, i - 600, -(longint'(i) * i), 0, 0, none);
		issue(OP_QUERY, 0, 0, 700, 0, none);
		issue(OP_QUERY, 0, 0, -64'sd2147483648, 0, none);
		drain();
		issue(OP_CLEAR, 0, 0, 0, 0, none);

		for (p = 0; p < 4; p++) begin
			idle_pct = (p == 1) ? 68 : (p == 3) ? 13 : 0;
			for (n = 0; n < 25; n++) begin
				pick = $urandom_range(0, 99);
				x = $signed($urandom);
				if ($urandom_range(0, 1) && env_cnt > 1)
					x = env_from[$urandom_range(1, env_cnt - 1)] + $signed($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 2) == 0)
					b = $signed(48'({$urandom, $urandom}));
				else
					b = $signed($urandom_range(0, 200000)) - 100000;
				if (pick < 4) begin
					issue(OP_CLEAR, $urandom, b, x, 0, none);
				end else if (pick < 10) begin
					k = (env_cnt > 0) ? env_k[env_cnt-1] - $urandom_range(0, 3) : 0;
					if (k < -64'sd2147483648 || pick < 6)
						issue(OP_NONE, $urandom, b, x, 0, none);
					else
						issue(OP_ADD, k, b, x, 0, none);
				end else if (pick < 55) begin
					if (env_cnt == 0)
						k = $signed($urandom);
					else
						k = env_k[env_cnt-1] + $urandom_range(1, 1 << $urandom_range(0, 26));
					if (k > 64'sd2147483647)
						issue(OP_CLEAR, 0, 0, 0, 0, none);
					else
						issue(OP_ADD, k, b, x, 0, none);
				end else begin
					issue(OP_QUERY, $urandom, b, x, 0, none);
				end
			end
			drain();
		end

		repeat (400) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
